### hw/rtl/hit_bitmap_event_decoder_defines.svh
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: assertion macros
// Shared concurrent assertion macros; they compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef HIT_BITMAP_EVENT_DECODER_DEFINES_SVH
`define HIT_BITMAP_EVENT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define HBED_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hit bitmap event decoder: assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define HBED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hit bitmap event decoder: assertion failed");
`else
`define HBED_ASSERT_IMPL(label, ante, cons)
`define HBED_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/hbed_pkg.sv
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: package
// Widths, codes, command format and helpers shared by the decoder modules.
// ---------------------------------------------------------------------------
package hbed_pkg;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int EVENT_W = 15;
  localparam int CHIP_W  = 7;
  localparam int UNIT_W  = 8;
  localparam int CHAN_W  = 5;
  localparam int TIME_W  = 16;
  localparam int COUNT_W = 16;

  // Number of live channels; bitmap bits at or above it are ignored
  localparam int CHANNELS = 32;
  localparam logic [WORD_W-1:0] CHAN_MASK =
    (CHANNELS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << CHANNELS) - 64'd1);

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Word position within an event
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_HEAD1,
    PH_BITMAP,
    PH_AFTER
  } phase_t;

  // Result kind
  typedef enum logic {
    KIND_HIT   = 1'b0,
    KIND_CLOSE = 1'b1
  } kind_t;

  // One unit of work for the back end: an event close or a bitmap with hits
  typedef struct packed {
    kind_t               kind;
    logic [EVENT_W-1:0]  evt_num;
    logic                rf_state;
    logic [CHIP_W-1:0]   chip_id;
    logic [UNIT_W-1:0]   unit_id;
    logic [TIME_W-1:0]   hit_time;
    logic                backward;
    logic [WORD_W-1:0]   mask;      // set bit = hit, indexed by channel
  } hbed_cmd_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Channel emitted at scan slot j: groups 24..31, 16..23, 8..15, 0..7
  function automatic logic [CHAN_W-1:0] chan_of(input logic [CHAN_W-1:0] slot);
    return {~slot[CHAN_W-1:3], slot[2:0]};
  endfunction

  // Reorder a channel mask into scan order (pure wiring)
  function automatic logic [WORD_W-1:0] scan_order(input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] r;
    logic [CHAN_W-1:0] slot;
    r = '0;
    for (int j = 0; j < WORD_W; j++) begin
      slot = CHAN_W'(j);
      r[j] = m[chan_of(slot)];
    end
    return r;
  endfunction

endpackage

### hw/rtl/hbed_in_if.sv
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: input channel
// Valid/ready channel carrying one readout stream word per beat.
// ---------------------------------------------------------------------------
interface hbed_in_if;
  logic                        valid;
  logic                        ready;
  logic [hbed_pkg::WORD_W-1:0] stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink   (input valid, input stream_word, output ready);
endinterface

### hw/rtl/hbed_out_if.sv
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: result channel
// Valid/ready channel carrying one hit or event-close result per beat.
// ---------------------------------------------------------------------------
interface hbed_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [hbed_pkg::EVENT_W-1:0] evt_num;
  logic                         rf_state;
  logic [hbed_pkg::CHIP_W-1:0]  chip_id;
  logic [hbed_pkg::UNIT_W-1:0]  unit_id;
  logic [hbed_pkg::CHAN_W-1:0]  channel;
  logic [hbed_pkg::TIME_W-1:0]  hit_time;
  logic [hbed_pkg::COUNT_W-1:0] hit_count;
  logic                         backward;
  logic                         last;

  modport source (output valid, output kind, output evt_num, output rf_state,
                  output chip_id, output unit_id, output channel, output hit_time,
                  output hit_count, output backward, output last, input ready);
  modport sink   (input valid, input kind, input evt_num, input rf_state,
                  input chip_id, input unit_id, input channel, input hit_time,
                  input hit_count, input backward, input last, output ready);
endinterface

### hw/rtl/hit_bitmap_event_decoder.sv
// The decoder takes one readout word per beat and can take a word in every
// cycle while its four-entry command queue has room. Headers and head words
// produce no work beyond the front end; a header that changes the event number
// queues one close result, and a bitmap with k hits queues one command that
// the back end expands into k results at one result per cycle while the
// result side is ready. Sustained throughput is therefore set by the back
// end's single result per cycle; the queue absorbs short bursts so the input
// and result sides stall independently.
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: top level
// Front end, command queue and back end of the readout word decoder.
// ---------------------------------------------------------------------------
`include "hit_bitmap_event_decoder_defines.svh"

module hit_bitmap_event_decoder (
  input  logic       clk,
  input  logic       rst_n,
  hbed_in_if.sink    in_ch,
  hbed_out_if.source out_ch
);
  import hbed_pkg::*;

  logic      q_push;
  logic      q_pop;
  hbed_cmd_t q_push_cmd;
  hbed_cmd_t q_head_cmd;
  q_stat_t   q_stat;

  // Word classification and event context
  hbed_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  // Decoupling queue
  hbed_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .stat     (q_stat)
  );

  // Result expansion and output register
  hbed_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head_cmd),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // Checks
  `HBED_ASSERT_IMPL(a_no_push_when_full, q_push, !q_stat.full)
  `HBED_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_stat.empty)
  `HBED_ASSERT_IMPL(a_close_is_last, out_ch.valid && out_ch.kind == KIND_CLOSE, out_ch.last && out_ch.channel == '0 && out_ch.hit_time == '0)
  `HBED_ASSERT_IMPL(a_hit_has_no_count, out_ch.valid && out_ch.kind == KIND_HIT, out_ch.hit_count == '0 && !out_ch.backward)
  `HBED_ASSERT_NEXT(a_push_lands, q_push && q_stat.empty && !q_pop, !q_stat.empty)

endmodule

### hw/rtl/hbed_front.sv
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: front end
// Tracks the word phase and event context, classifies each stream word and
// queues close and bitmap commands for the back end.
// ---------------------------------------------------------------------------
module hbed_front (
  input  logic                clk,
  input  logic                rst_n,
  hbed_in_if.sink             in_ch,
  input  hbed_pkg::q_stat_t   q_stat,
  output logic                q_push,
  output hbed_pkg::hbed_cmd_t q_cmd
);
  import hbed_pkg::*;

  phase_t              phase_r,       phase_nxt;
  logic [EVENT_W-1:0]  open_event_r,  open_event_nxt;
  logic                event_valid_r, event_valid_nxt;
  logic                event_rf_r,    event_rf_nxt;
  logic [CHIP_W-1:0]   chip_r,        chip_nxt;
  logic [UNIT_W-1:0]   unit_r,        unit_nxt;
  logic [TIME_W-1:0]   time_r,        time_nxt;

  logic                accept;
  logic                is_header;
  logic                is_head;
  logic                is_bitmap;
  logic [WORD_W-1:0]   word;
  logic [EVENT_W-1:0]  hdr_event;
  logic                hdr_close;
  logic [WORD_W-1:0]   hit_mask;

  // Take a beat whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign word        = in_ch.stream_word;
  assign hdr_event   = word[EVENT_W-1:0];
  assign hdr_close   = event_valid_r && (hdr_event != open_event_r);
  assign hit_mask    = ~word & CHAN_MASK;

  // Classify the word and compute the next context
  always_comb begin
    is_header = 1'b0;
    is_head   = 1'b0;
    is_bitmap = 1'b0;
    case (phase_r)
      PH_HEADER: is_header = 1'b1;
      PH_HEAD1:  is_head   = 1'b1;
      PH_BITMAP: is_bitmap = 1'b1;
      PH_AFTER: begin
        is_head   = word[WORD_W-1];
        is_header = !word[WORD_W-1];
      end
      default:   is_header = 1'b1;
    endcase

    phase_nxt       = phase_r;
    open_event_nxt  = open_event_r;
    event_valid_nxt = event_valid_r;
    event_rf_nxt    = event_rf_r;
    chip_nxt        = chip_r;
    unit_nxt        = unit_r;
    time_nxt        = time_r;

    if (accept) begin
      if (is_header) begin
        open_event_nxt  = hdr_event;
        event_valid_nxt = 1'b1;
        event_rf_nxt    = word[EVENT_W];
        phase_nxt       = PH_HEAD1;
      end
      if (is_head) begin
        chip_nxt  = word[30:24];
        unit_nxt  = word[23:16];
        time_nxt  = word[TIME_W-1:0];
        phase_nxt = PH_BITMAP;
      end
      if (is_bitmap) begin
        phase_nxt = PH_AFTER;
      end
    end
  end

  // Command for the back end
  always_comb begin
    q_cmd          = '0;
    q_cmd.evt_num  = open_event_r;
    q_cmd.rf_state = event_rf_r;
    if (is_header) begin
      q_cmd.kind     = KIND_CLOSE;
      q_cmd.backward = open_event_r > hdr_event;
    end else begin
      q_cmd.kind    = KIND_HIT;
      q_cmd.chip_id = chip_r;
      q_cmd.unit_id = unit_r;
      q_cmd.hit_time = time_r;
      q_cmd.mask    = hit_mask;
    end
    q_push = accept && ((is_header && hdr_close) || (is_bitmap && (hit_mask != '0)));
  end

  // Context registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      open_event_r  <= '0;
      event_valid_r <= 1'b0;
      event_rf_r    <= 1'b0;
      chip_r        <= '0;
      unit_r        <= '0;
      time_r        <= '0;
    end else begin
      phase_r       <= phase_nxt;
      open_event_r  <= open_event_nxt;
      event_valid_r <= event_valid_nxt;
      event_rf_r    <= event_rf_nxt;
      chip_r        <= chip_nxt;
      unit_r        <= unit_nxt;
      time_r        <= time_nxt;
    end
  end

endmodule

### hw/rtl/hbed_queue.sv
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: command queue
// Small register FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module hbed_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hbed_pkg::hbed_cmd_t push_cmd,
  input  logic                pop,
  output hbed_pkg::hbed_cmd_t head_cmd,
  output hbed_pkg::q_stat_t   stat
);
  import hbed_pkg::*;

  hbed_cmd_t            entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r,  count_nxt;

  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hw/rtl/hbed_back.sv
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: back end
// Expands queued commands into results, one per cycle while out_ch is ready,
// keeps the event hit count and holds the result in an output register.
// ---------------------------------------------------------------------------
module hbed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hbed_pkg::hbed_cmd_t q_head,
  input  hbed_pkg::q_stat_t   q_stat,
  output logic                q_pop,
  hbed_out_if.source          out_ch
);
  import hbed_pkg::*;

  // Command in progress
  logic               cur_valid_r, cur_valid_nxt;
  hbed_cmd_t          cur_r;
  logic [WORD_W-1:0]  cur_mask_r;    // remaining hits, scan order
  logic [COUNT_W-1:0] hits_r, hits_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r;
  logic [EVENT_W-1:0] out_event_r;
  logic               out_rf_r;
  logic [CHIP_W-1:0]  out_chip_r;
  logic [UNIT_W-1:0]  out_unit_r;
  logic [CHAN_W-1:0]  out_chan_r;
  logic [TIME_W-1:0]  out_time_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_back_r;
  logic               out_last_r;

  logic               is_close;
  logic               load;
  logic               done;
  logic [CHAN_W-1:0]  slot;
  logic [WORD_W-1:0]  mask_rem;

  // First remaining hit in scan order
  always_comb begin
    slot = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cur_mask_r[j]) begin
        slot = CHAN_W'(j);
      end
    end
  end

  assign mask_rem = cur_mask_r & (cur_mask_r - 1'b1);
  assign is_close = (cur_r.kind == KIND_CLOSE);
  assign load     = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign done     = is_close || (mask_rem == '0);
  assign q_pop    = !q_stat.empty && (!cur_valid_r || (load && done));

  // Control next state
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    cur_valid_nxt = cur_valid_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
    end else if (load && done) begin
      cur_valid_nxt = 1'b0;
    end

    // Saturating hit count, cleared when the event closes
    hits_nxt = hits_r;
    if (load) begin
      if (is_close) begin
        hits_nxt = '0;
      end else if (hits_r != COUNT_MAX) begin
        hits_nxt = hits_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      hits_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_valid_r <= cur_valid_nxt;
      hits_r      <= hits_nxt;
    end
  end

  // Command payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r      <= q_head;
      cur_mask_r <= scan_order(q_head.mask);
    end else if (load) begin
      cur_mask_r <= mask_rem;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r  <= cur_r.kind;
      out_event_r <= cur_r.evt_num;
      out_rf_r    <= cur_r.rf_state;
      if (is_close) begin
        out_chip_r  <= '0;
        out_unit_r  <= '0;
        out_chan_r  <= '0;
        out_time_r  <= '0;
        out_count_r <= hits_r;
        out_back_r  <= cur_r.backward;
        out_last_r  <= 1'b1;
      end else begin
        out_chip_r  <= cur_r.chip_id;
        out_unit_r  <= cur_r.unit_id;
        out_chan_r  <= chan_of(slot);
        out_time_r  <= cur_r.hit_time;
        out_count_r <= '0;
        out_back_r  <= 1'b0;
        out_last_r  <= (mask_rem == '0);
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.evt_num   = out_event_r;
  assign out_ch.rf_state  = out_rf_r;
  assign out_ch.chip_id   = out_chip_r;
  assign out_ch.unit_id   = out_unit_r;
  assign out_ch.channel   = out_chan_r;
  assign out_ch.hit_time  = out_time_r;
  assign out_ch.hit_count = out_count_r;
  assign out_ch.backward  = out_back_r;
  assign out_ch.last      = out_last_r;

endmodule

### bench/tb_hit_bitmap_event_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hit bitmap event decoder: testbench
// Drives readout word streams (directed events, a long result stall and
// random event streams) into the decoder, predicts every hit and
// event-close result, and checks each result beat field by field.
// ---------------------------------------------------------------------------
module tb_hit_bitmap_event_decoder;
  import hbed_pkg::*;

  localparam int RANDOM_WORDS = 296;
  localparam int IDLE_PCT     = 19;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 1_000_000;

  // One expected result beat
  typedef struct packed {
    kind_t               kind;
    logic [EVENT_W-1:0]  evt;
    logic                rf;
    logic [CHIP_W-1:0]   chip;
    logic [UNIT_W-1:0]   unit;
    logic [CHAN_W-1:0]   chan;
    logic [TIME_W-1:0]   tstamp;
    logic [COUNT_W-1:0]  count;
    logic                backward;
    logic                last;
  } decoded_result_t;

  logic clk = 1'b0;
  logic rst_n;

  hbed_in_if  in_ch();
  hbed_out_if out_ch();

  hit_bitmap_event_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder state as the predictor sees it
  phase_t             dec_phase  = PH_HEADER;
  logic [EVENT_W-1:0] open_evt   = '0;
  logic               evt_open   = 1'b0;
  logic               open_rf    = 1'b0;
  logic [CHIP_W-1:0]  rec_chip   = '0;
  logic [UNIT_W-1:0]  rec_unit   = '0;
  logic [TIME_W-1:0]  rec_tstamp = '0;
  logic [COUNT_W-1:0] evt_hits   = '0;

  decoded_result_t    expected_q[$];
  int                 fail_count  = 0;
  int                 words_sent  = 0;
  bit                 send_idle   = 1'b1;
  bit                 recv_idle   = 1'b1;
  int                 hold_request = 0;
  logic [EVENT_W-1:0] gen_evt     = '0;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Header word: closes the open event if the number changes
  function automatic void take_header(input logic [WORD_W-1:0] w);
    decoded_result_t    r;
    logic [EVENT_W-1:0] evt;
    evt = w[EVENT_W-1:0];
    if (evt_open && evt != open_evt) begin
      r          = '0;
      r.kind     = KIND_CLOSE;
      r.evt      = open_evt;
      r.rf       = open_rf;
      r.count    = evt_hits;
      r.backward = (open_evt > evt);
      r.last     = 1'b1;
      expected_q.insert(expected_q.size(), r);
      evt_hits = '0;
    end
    open_evt  = evt;
    evt_open  = 1'b1;
    open_rf   = w[15];
    dec_phase = PH_HEAD1;
  endfunction

  // Record head word; bit 31 is not part of the chip
  function automatic void take_head(input logic [WORD_W-1:0] w);
    rec_chip   = w[30:24];
    rec_unit   = w[23:16];
    rec_tstamp = w[15:0];
    dec_phase  = PH_BITMAP;
  endfunction

  // Predict the results of one accepted stream word
  function automatic void decode_word(input logic [WORD_W-1:0] w);
    decoded_result_t r;
    int              ch;
    int              n_before;
    case (dec_phase)
      PH_HEADER: take_header(w);
      PH_HEAD1:  take_head(w);
      PH_BITMAP: begin
        // zero bit = hit, scanned 24..31, 16..23, 8..15, 0..7
        n_before = expected_q.size();
        for (int g = 3; g >= 0; g--) begin
          for (int i = 0; i < 8; i++) begin
            ch = g * 8 + i;
            if (ch < CHANNELS && !w[ch]) begin
              r        = '0;
              r.kind   = KIND_HIT;
              r.evt    = open_evt;
              r.rf     = open_rf;
              r.chip   = rec_chip;
              r.unit   = rec_unit;
              r.chan   = CHAN_W'(ch);
              r.tstamp = rec_tstamp;
              expected_q.insert(expected_q.size(), r);
              if (evt_hits != COUNT_MAX) evt_hits++;
            end
          end
        end
        if (expected_q.size() > n_before)
          expected_q[expected_q.size() - 1].last = 1'b1;
        dec_phase = PH_AFTER;
      end
      default: begin
        if (w[31]) take_head(w);
        else take_header(w);
      end
    endcase
  endfunction

  // Input monitor: predict on every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) decode_word(in_ch.stream_word);
  end

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: each beat against the oldest expectation
  always @(posedge clk) begin : check_results
    decoded_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: kind %0d event %0d channel %0d",
               out_ch.kind, out_ch.evt_num, out_ch.channel);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("evt_num", want.evt, out_ch.evt_num);
        check_field("rf_state", want.rf, out_ch.rf_state);
        check_field("chip_id", want.chip, out_ch.chip_id);
        check_field("unit_id", want.unit, out_ch.unit_id);
        check_field("channel", want.chan, out_ch.channel);
        check_field("hit_time", want.tstamp, out_ch.hit_time);
        check_field("hit_count", want.count, out_ch.hit_count);
        check_field("backward", want.backward, out_ch.backward);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // Result side ready: random stalls, plus long holds on request
  initial begin : result_ready
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (recv_idle) begin
        out_ch.ready = ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Send one stream word; called and returns at a falling edge
  task automatic send_word(input logic [WORD_W-1:0] w);
    while (send_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.stream_word = w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic logic [WORD_W-1:0] header_word(input logic [EVENT_W-1:0] evt);
    return {1'b0, 15'($urandom), 1'($urandom_range(1)), evt};
  endfunction

  function automatic logic [WORD_W-1:0] head_word(input logic top);
    logic [WORD_W-1:0] w;
    w     = $urandom;
    w[31] = top;
    return w;
  endfunction

  // Bitmaps from sparse to full
  function automatic logic [WORD_W-1:0] bitmap_word();
    logic [WORD_W-1:0] m;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        m = '1;
        repeat ($urandom_range(1, 3)) m[$urandom_range(31)] = 1'b0;
      end
      4, 5, 6: m = $urandom;
      7:       m = $urandom | $urandom;
      8:       m = '1;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Edge cases: first header, full and empty bitmaps, same-number header,
  // backward and forward closes, empty event, head top bit, field extremes
  task automatic test_directed_events();
    send_word(32'h0000_8005);  // first header after reset, event 5, RF set
    send_word(32'hFFFF_FFFF);  // first head with top bit set, all fields max
    send_word(32'h0000_0000);  // full bitmap: 32 hits
    send_word(32'h8000_0000);  // head after bitmap, all fields zero
    send_word(32'hFFFF_FFFF);  // no hits
    send_word(32'h0000_0005);  // same event, RF cleared: stays open
    send_word(32'h2A5A_C3E1);  // first head with top bit clear
    send_word(32'hFEFF_7FFE);  // hits on 24, 15, 0
    send_word(32'h0000_8003);  // backward: closes event 5
    send_word(32'h8155_1234);
    send_word(32'hFFFF_FFFF);  // event 3 gets no hits
    send_word(32'h0000_7FFF);  // forward: closes event 3 with count zero
    send_word(32'h80AA_5555);
    send_word(32'h7FFF_FFFF);  // only channel 31
    send_word(32'h0000_0000);  // event 0: closes max event, backward
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FFFE);  // only channel 0
    send_word(32'h7FFF_0000);  // same event 0, high header bits set
    send_word(32'h9234_5678);
    send_word(32'h5555_5555);  // alternating hits
    send_word(32'h0000_0001);  // closes event 0
    gen_evt = 15'd1;
  endtask

  // Stall the result side long enough for the queue to fill and the input
  // to back up behind it
  task automatic test_backpressure_hold();
    gen_evt = gen_evt + 1'b1;
    send_word(header_word(gen_evt));
    hold_request = 300;
    for (int r = 0; r < 6; r++) begin
      send_word(head_word(r == 0 ? 1'($urandom_range(1)) : 1'b1));
      send_word('0);
    end
  endtask

  // Mostly well-formed events with random content, some stray words
  task automatic test_random_stream();
    int first_word;
    int nrec;
    int done;
    first_word = words_sent;
    done       = 0;
    while (done < RANDOM_WORDS) begin
      // one stretch with no idling on either side
      send_idle = !(done >= 120 && done < 200);
      recv_idle = send_idle;
      if ($urandom_range(99) < 8) begin
        send_word($urandom);
      end else begin
        case ($urandom_range(9))
          0, 1, 2: gen_evt = gen_evt;
          3, 4, 5: gen_evt = gen_evt + 1'b1;
          6, 7:    gen_evt = EVENT_W'($urandom);
          default: gen_evt = gen_evt - EVENT_W'($urandom_range(1, 50));
        endcase
        send_word(header_word(gen_evt));
        nrec = $urandom_range(1, 3);
        for (int r = 0; r < nrec; r++) begin
          send_word(head_word(r == 0 ? 1'($urandom_range(1)) : 1'b1));
          send_word(bitmap_word());
        end
      end
      done = words_sent - first_word;
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Main sequence
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.stream_word = '0;
    rst_n             = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_backpressure_hold();
    test_random_stream();

    in_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/hbed_pkg.sv
hw/rtl/hbed_in_if.sv
hw/rtl/hbed_out_if.sv
hw/rtl/hbed_front.sv
hw/rtl/hbed_queue.sv
hw/rtl/hbed_back.sv
hw/rtl/hit_bitmap_event_decoder.sv
bench/tb_hit_bitmap_event_decoder.sv
